// ----- hw/rtl/m3ms_pkg.sv -----
// shared constants and the median-of-three helper for the median/moving-sum filter
package m3ms_pkg;

    localparam int CFG_BITS = 7;
    localparam logic [CFG_BITS-1:0] WINDOW_COUNT_RESET = 7'd48;
    localparam int MAX_WINDOW_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 20;
    localparam int MEDIAN_DEPTH = 3;
    localparam int MEDIAN_CELLS = MEDIAN_DEPTH - 1;
    localparam int MIN_WINDOW = 2;

    // middle value of three unsigned samples
    function automatic logic [31:0] mid_of_three(
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [31:0] c
    );
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            mid = lo;
        end else if (c >= hi) begin
            mid = hi;
        end else begin
            mid = c;
        end
        return mid;
    endfunction

endpackage

// ----- hw/rtl/m3ms_cell.sv -----
// one cell of the median history chain: a sample and its occupied flag
module m3ms_cell
    import m3ms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_occ,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic                   o_occ
);

    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_occ;

    // occupied flag walks down the chain with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_shift) begin
            r_occ <= i_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;
    assign o_occ    = r_occ;

endmodule

// ----- hw/rtl/m3ms_window.sv -----
// moving window ring: sample memory, valid bits, ring index and full flag
module m3ms_window
    import m3ms_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [CFG_BITS-1:0]    i_count,
    input  logic [SAMPLE_BITS-1:0] i_data,
    output logic [SAMPLE_BITS-1:0] o_old,
    output logic                   o_full
);

    localparam int IW = $clog2(MAX_WINDOW);
    localparam int CW = (CFG_BITS > IW + 1) ? CFG_BITS : IW + 1;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  r_valid;
    logic [IW-1:0]          r_idx;
    logic                   r_full;
    logic [SAMPLE_BITS-1:0] r_rd;
    logic                   r_rd_valid;

    logic [CW-1:0] w_count_ext;
    logic [CW-1:0] w_count_eff;
    logic [CW-1:0] w_nxt_ext;
    logic          w_wrap;
    logic [IW-1:0] w_cur;
    logic [IW-1:0] w_nxt;

    // clamp the programmed count into the legal range
    always_comb begin
        w_count_ext = CW'(i_count);
        if (w_count_ext < CW'(MIN_WINDOW)) begin
            w_count_eff = CW'(MIN_WINDOW);
        end else if (w_count_ext > CW'(MAX_WINDOW)) begin
            w_count_eff = CW'(MAX_WINDOW);
        end else begin
            w_count_eff = w_count_ext;
        end
    end

    assign w_cur     = r_idx;
    assign w_nxt_ext = CW'(r_idx) + CW'(1);
    assign w_wrap    = (w_nxt_ext >= w_count_eff);
    assign w_nxt     = w_wrap ? '0 : w_nxt_ext[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_idx      <= '0;
            r_full     <= 1'b0;
            r_rd_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid[w_cur] <= 1'b1;
            r_rd_valid     <= r_valid[w_nxt];
            r_idx          <= w_nxt;
            r_full         <= r_full | w_wrap;
        end
    end

    // write at the current slot, read the slot the index moves to
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[w_cur] <= i_data;
            r_rd         <= r_mem[w_nxt];
        end
    end

    // a slot never written since reset reads as zero
    assign o_old  = r_rd_valid ? r_rd : '0;
    assign o_full = r_full;

    a_full_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("window full flag dropped");

    a_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_idx) < CW'(MAX_WINDOW))
        else $error("window index beyond ring");

    a_slot_marked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_valid[$past(w_cur)])
        else $error("written slot not marked valid");

endmodule

// ----- hw/rtl/median3_moving_sum.sv -----
// top level: median-of-three pre-filter feeding a moving-sum window
// datapath: an accepted request waits in stage one and moves into the output
//   register once that register is free, which presents it on the outputs
// throughput: one request per cycle unless stalled, set by the single-port-pair
//   window memory (a write at the current slot, a read of the next, per request)
// reset: synchronous, active low; clears chain occupancy, valid and ring full flags,
//   index, total and all window valid bits; requests are taken right after reset
module median3_moving_sum
    import m3ms_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [CFG_BITS-1:0]                        i_cfg_wdata,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic [SAMPLE_BITS-1:0]                     i_pressure_sample,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]  o_pressure_total,
    output logic [SAMPLE_BITS-1:0]                     o_filtered_sample,
    output logic                                       o_window_full
);

    // total wide enough for a full window of maximum samples
    localparam int TOTAL_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

    // configuration
    logic [CFG_BITS-1:0] r_window_count;

    // median chain
    logic [SAMPLE_BITS-1:0] w_cell_q   [MEDIAN_CELLS];
    logic                   w_cell_occ [MEDIAN_CELLS];
    logic [SAMPLE_BITS-1:0] w_filt;

    // pipeline: stage one holds the filtered sample while the old slot is read
    logic                   w_accept;
    logic                   w_move;
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_filt;
    logic [SAMPLE_BITS-1:0] w_old;
    logic                   w_win_full;

    // output register; the running total is also the presented total
    logic                   r_o_valid;
    logic [TOTAL_BITS-1:0]  r_total;
    logic [SAMPLE_BITS-1:0] r_o_filt;
    logic                   r_o_full;

    // window count register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_count <= WINDOW_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_window_count <= i_cfg_wdata;
        end
    end

    // handshake: stage one moves on whenever the output register is free,
    // so a new request is taken in the same cycle a finished one leaves
    assign w_move   = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall  = r_s1_valid && !w_move;
    assign w_accept = i_valid && !o_stall;

    // history chain: cell 0 takes the new sample, cell 1 the previous one
    genvar g;
    generate
        for (g = 0; g < MEDIAN_CELLS; g++) begin : g_cell
            logic [SAMPLE_BITS-1:0] w_d;
            logic                   w_occ_in;
            if (g == 0) begin : g_head
                assign w_d      = i_pressure_sample;
                assign w_occ_in = 1'b1;
            end else begin : g_link
                assign w_d      = w_cell_q[g-1];
                assign w_occ_in = w_cell_occ[g-1];
            end
            m3ms_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_accept),
                .i_sample (w_d),
                .i_occ    (w_occ_in),
                .o_sample (w_cell_q[g]),
                .o_occ    (w_cell_occ[g])
            );
        end
    endgenerate

    // median once two earlier samples are held, raw sample before that
    assign w_filt = w_cell_occ[MEDIAN_CELLS-1]
                  ? SAMPLE_BITS'(mid_of_three(32'(i_pressure_sample),
                                              32'(w_cell_q[0]),
                                              32'(w_cell_q[1])))
                  : i_pressure_sample;

    // window ring: written with the filtered sample on accept, the slot the
    // index moves to is read back at the same edge (never the same slot)
    m3ms_window #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_accept),
        .i_count (r_window_count),
        .i_data  (w_filt),
        .o_old   (w_old),
        .o_full  (w_win_full)
    );

    // stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_filt <= w_filt;
        end
    end

    // output stage: total adds the new value and drops the next slot,
    // wrapping modulo the total width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_total   <= '0;
        end else if (w_move) begin
            r_o_valid <= 1'b1;
            r_total   <= r_total + TOTAL_BITS'(r_s1_filt) - TOTAL_BITS'(w_old);
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // full flag is sampled before the next request can update it
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_o_filt <= r_s1_filt;
            r_o_full <= w_win_full;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_pressure_total  = r_total;
    assign o_filtered_sample = r_o_filt;
    assign o_window_full     = r_o_full;

    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_rst_n) |=> r_s1_valid)
        else $error("accepted request missing from stage one");

    a_raw_pass : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_rst_n && !w_cell_occ[MEDIAN_CELLS-1])
            |=> (r_s1_filt == $past(i_pressure_sample)))
        else $error("raw sample not passed before median chain filled");

    a_out_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a request in stage one");

endmodule
